@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL of the keyword tokenizer.
// Each macro expands to one labeled concurrent assertion on clk, gated by rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that cond implies prop at every rising edge of clk outside reset.
`define ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`endif

@@ hw/rtl/skt_pkg.sv @@
// Types, character codes and keyword constants of the SQL keyword tokenizer.
// Used by sql_keyword_tokenizer; depends on nothing else.
package skt_pkg;

  typedef enum logic [3:0] {
    TOK_EOF     = 4'd0,
    TOK_IDENT   = 4'd1,
    TOK_CREATE  = 4'd2,
    TOK_TABLE   = 4'd3,
    TOK_NULL    = 4'd4,
    TOK_INTEGER = 4'd5,
    TOK_REAL    = 4'd6,
    TOK_TEXT    = 4'd7,
    TOK_BLOB    = 4'd8,
    TOK_OPEN    = 4'd9,
    TOK_CLOSE   = 4'd10,
    TOK_SEMI    = 4'd11,
    TOK_UNREC   = 4'd12
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] offset;
    logic [7:0]  len;
    logic        last;
  } tok_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Identifier prefix holds up to seven bytes, first byte in the low bits.
  localparam int unsigned PREFIX_BYTES = 7;
  localparam int unsigned PREFIX_BITS  = 8 * PREFIX_BYTES;

  localparam logic [PREFIX_BITS-1:0] KW_CREATE  = 56'h00_45_54_41_45_52_43;
  localparam logic [PREFIX_BITS-1:0] KW_TABLE   = 56'h00_00_45_4C_42_41_54;
  localparam logic [PREFIX_BITS-1:0] KW_NULL    = 56'h00_00_00_4C_4C_55_4E;
  localparam logic [PREFIX_BITS-1:0] KW_INTEGER = 56'h52_45_47_45_54_4E_49;
  localparam logic [PREFIX_BITS-1:0] KW_REAL    = 56'h00_00_00_4C_41_45_52;
  localparam logic [PREFIX_BITS-1:0] KW_TEXT    = 56'h00_00_00_54_58_45_54;
  localparam logic [PREFIX_BITS-1:0] KW_BLOB    = 56'h00_00_00_42_4F_4C_42;

  // Result queue between the lexer and the token channel.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Bytes past the count stay zero, so a full-width compare plus length is exact.
  function automatic tok_kind_t keyword_kind(logic [7:0] count,
                                             logic [PREFIX_BITS-1:0] prefix);
    tok_kind_t k;
    k = TOK_IDENT;
    if (count == 8'd6 && prefix == KW_CREATE) k = TOK_CREATE;
    else if (count == 8'd5 && prefix == KW_TABLE) k = TOK_TABLE;
    else if (count == 8'd4 && prefix == KW_NULL) k = TOK_NULL;
    else if (count == 8'd7 && prefix == KW_INTEGER) k = TOK_INTEGER;
    else if (count == 8'd4 && prefix == KW_REAL) k = TOK_REAL;
    else if (count == 8'd4 && prefix == KW_TEXT) k = TOK_TEXT;
    else if (count == 8'd4 && prefix == KW_BLOB) k = TOK_BLOB;
    return k;
  endfunction

endpackage

@@ hw/rtl/sql_keyword_tokenizer.sv @@
// Streaming SQL keyword tokenizer: one byte in, zero to two tokens out.
// Depends on skt_pkg and assert_macros.svh.
//
// Usage:
//   Input channel char_valid/char_ready carries one byte per item (char_in).
//   A zero byte ends the string, emits EOF and returns the position to zero.
//   Output channel token_valid/token_ready carries one token per item:
//   token_kind, token_offset, token_len and last_of_run, which marks the
//   last token caused by one input byte.
//   Tokens caused by a byte are written into the result queue when that
//   byte is accepted and presented from its head. Throughput: one byte per
//   cycle while the consumer takes one token per cycle; a byte that closes
//   an identifier and also yields its own token puts two tokens into the
//   four-entry result queue. char_ready is high while the queue has room
//   for two tokens, so the queue fill count sets the input rate when the
//   receiver stalls; tokens are held in order and none are dropped.
//   Reset (rst, synchronous) empties the queue, closes any identifier and
//   clears the position; the block takes a byte in the first cycle after.
`include "assert_macros.svh"

module sql_keyword_tokenizer #(
  parameter int unsigned POSITION_BITS    = 16,
  parameter int unsigned MAX_TOKEN_LENGTH = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  logic [7:0]          char_in,
  output logic                token_valid,
  input  logic                token_ready,
  output skt_pkg::tok_kind_t  token_kind,
  output logic [15:0]         token_offset,
  output logic [7:0]          token_len,
  output logic                last_of_run
);

  localparam logic [7:0] LenCap =
    8'((MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255);
  localparam int unsigned CntBits = skt_pkg::QPTR_BITS + 1;

  // lexer state
  logic                            in_ident, in_ident_next;
  logic [POSITION_BITS-1:0]        ident_begin, ident_begin_next;
  logic [7:0]                      ident_count, ident_count_next;
  logic [skt_pkg::PREFIX_BITS-1:0] ident_prefix, ident_prefix_next;
  logic [POSITION_BITS-1:0]        char_position, char_position_next;

  // result queue
  skt_pkg::tok_t                   queue [skt_pkg::QUEUE_DEPTH];
  logic [skt_pkg::QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [CntBits-1:0]              fill, fill_next;

  logic          char_fire, token_fire;
  logic          is_let, extend, ident_close, char_emit, ident_start;
  logic [1:0]    push_n;
  skt_pkg::tok_t tok_a, tok_b, slot0;
  skt_pkg::tok_t head;

  assign char_ready  = (fill <= CntBits'(skt_pkg::QUEUE_DEPTH - 2));
  assign char_fire   = char_valid && char_ready;
  assign token_valid = (fill != '0);
  assign token_fire  = token_valid && token_ready;

  assign head         = queue[rd_ptr];
  assign token_kind   = head.kind;
  assign token_offset = head.offset;
  assign token_len    = head.len;
  assign last_of_run  = head.last;

  always_comb begin
    is_let      = skt_pkg::is_letter(char_in);
    extend      = in_ident && is_let;
    ident_close = in_ident && !is_let;
    ident_start = !extend && (is_let || char_in == skt_pkg::CH_UNDER);

    char_emit = 1'b1;
    tok_b.kind   = skt_pkg::TOK_UNREC;
    tok_b.offset = 16'(char_position);
    tok_b.len    = 8'd1;
    tok_b.last   = 1'b1;
    case (char_in)
      skt_pkg::CH_NUL: begin
        tok_b.kind = skt_pkg::TOK_EOF;
        tok_b.len  = 8'd0;
      end
      skt_pkg::CH_SPACE, skt_pkg::CH_TAB, skt_pkg::CH_CR: char_emit = 1'b0;
      skt_pkg::CH_OPEN:  tok_b.kind = skt_pkg::TOK_OPEN;
      skt_pkg::CH_CLOSE: tok_b.kind = skt_pkg::TOK_CLOSE;
      skt_pkg::CH_SEMI:  tok_b.kind = skt_pkg::TOK_SEMI;
      default: begin
        if (is_let || char_in == skt_pkg::CH_UNDER) char_emit = 1'b0;
      end
    endcase

    tok_a.kind   = skt_pkg::keyword_kind(ident_count, ident_prefix);
    tok_a.offset = 16'(ident_begin);
    tok_a.len    = ident_count;
    tok_a.last   = !char_emit;

    slot0  = ident_close ? tok_a : tok_b;
    push_n = char_fire ? (2'({1'b0, ident_close}) + 2'({1'b0, char_emit})) : 2'd0;

    in_ident_next      = in_ident;
    ident_begin_next   = ident_begin;
    ident_count_next   = ident_count;
    ident_prefix_next  = ident_prefix;
    char_position_next = char_position;
    if (char_fire) begin
      char_position_next = char_position + POSITION_BITS'(1);
      if (extend) begin
        if (ident_count < 8'(skt_pkg::PREFIX_BYTES)) begin
          ident_prefix_next = ident_prefix |
            (skt_pkg::PREFIX_BITS'(char_in) << {ident_count[2:0], 3'b000});
        end
        if (ident_count < LenCap) ident_count_next = ident_count + 8'd1;
      end else begin
        in_ident_next = ident_start;
        if (ident_start) begin
          ident_begin_next  = char_position;
          ident_count_next  = 8'd1;
          ident_prefix_next = skt_pkg::PREFIX_BITS'(char_in);
        end
        if (char_in == skt_pkg::CH_NUL) char_position_next = '0;
      end
    end

    fill_next = fill + CntBits'(push_n) - CntBits'(token_fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_ident      <= 1'b0;
      ident_begin   <= '0;
      ident_count   <= '0;
      ident_prefix  <= '0;
      char_position <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      fill          <= '0;
    end else begin
      in_ident      <= in_ident_next;
      ident_begin   <= ident_begin_next;
      ident_count   <= ident_count_next;
      ident_prefix  <= ident_prefix_next;
      char_position <= char_position_next;
      wr_ptr        <= wr_ptr + skt_pkg::QPTR_BITS'(push_n);
      if (token_fire) rd_ptr <= rd_ptr + skt_pkg::QPTR_BITS'(1);
      fill          <= fill_next;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue[wr_ptr] <= slot0;
    if (push_n == 2'd2) queue[wr_ptr + skt_pkg::QPTR_BITS'(1)] <= tok_b;
  end

  `ASSERT_CLK(a_fill_bound, fill <= CntBits'(skt_pkg::QUEUE_DEPTH), "queue overfilled")
  `ASSERT_IMPL(a_ident_nonempty, in_ident, ident_count != 8'd0, "open identifier empty")
  `ASSERT_IMPL(a_nul_clears_pos, char_fire && char_in == skt_pkg::CH_NUL,
               ##1 char_position == '0, "position not cleared after end of string")
  `ASSERT_IMPL(a_eof_len, token_valid && token_kind == skt_pkg::TOK_EOF,
               token_len == 8'd0 && last_of_run, "bad EOF token")

endmodule
